### rtl/hysteretic_relperm_land_trapping_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the relative permeability unit
// Concurrent assertion wrappers that compile away when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef HYSTERETIC_RELPERM_LAND_TRAPPING_UNIT_MACROS_SVH
`define HYSTERETIC_RELPERM_LAND_TRAPPING_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is active.
`define HRLT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("hrlt: assertion failed");
// Next-cycle implication, disabled while reset is active.
`define HRLT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("hrlt: assertion failed");
`else
`define HRLT_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define HRLT_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### rtl/hrlt_pkg.sv
// ----------------------------------------------------------------------------
// Relative permeability unit package
// Fixed-point widths, register indexes and the divider stage type.
// ----------------------------------------------------------------------------
package hrlt_pkg;

  localparam int FracBits = 16;
  // Effective saturations run from zero to one inclusive.
  localparam int SatW = FracBits + 1;
  localparam logic [SatW-1:0] OneQ = SatW'(1) << FracBits;

  // Shared divider geometry.
  localparam int QuoW = 24;
  localparam int NumW = 52;
  localparam int DenW = 33;

  localparam logic [24:0] SlopeMax = 25'h0FF_FFFF;
  localparam logic [24:0] SlopeMin = 25'h100_0000;

  typedef enum logic [1:0] {
    CfgResidualWater = 2'd0,
    CfgMaxNonwetKr   = 2'd1,
    CfgMaxWetKr      = 2'd2,
    CfgMaxTrapped    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [DenW-1:0] rem;
    logic [QuoW-1:0] low;
    logic [DenW-1:0] den;
    logic [QuoW-1:0] quo;
    logic            ovf;
  } div_stage_t;

endpackage

### rtl/hrlt_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage; flags quotients that do not fit the output.
// ----------------------------------------------------------------------------
module hrlt_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [hrlt_pkg::NumW-1:0]     num_i,
  input  logic [hrlt_pkg::DenW-1:0]     den_i,
  output logic [hrlt_pkg::QuoW-1:0]     quo_o,
  output logic                          ovf_o
);
  import hrlt_pkg::*;

  div_stage_t st_q [QuoW];
  div_stage_t st_d [QuoW];
  div_stage_t init;

  function automatic div_stage_t div_step(div_stage_t a);
    logic [DenW:0] r2;
    div_stage_t    b;
    b  = a;
    r2 = {a.rem, a.low[QuoW-1]};
    b.low = a.low << 1;
    if (r2 >= {1'b0, a.den}) begin
      b.rem = DenW'(r2 - {1'b0, a.den});
      b.quo = {a.quo[QuoW-2:0], 1'b1};
    end else begin
      b.rem = r2[DenW-1:0];
      b.quo = {a.quo[QuoW-2:0], 1'b0};
    end
    return b;
  endfunction

  always_comb begin
    // The quotient overflows when the high part alone reaches the divisor.
    init.ovf = DenW'(num_i[NumW-1:QuoW]) >= den_i;
    init.rem = init.ovf ? '0 : DenW'(num_i[NumW-1:QuoW]);
    init.low = num_i[QuoW-1:0];
    init.den = den_i;
    init.quo = '0;
    st_d[0] = div_step(init);
    for (int k = 1; k < QuoW; k++) begin
      st_d[k] = div_step(st_q[k-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign quo_o = st_q[QuoW-1].quo;
  assign ovf_o = st_q[QuoW-1].ovf;

endmodule

### rtl/hysteretic_relperm_land_trapping_unit.sv
// ----------------------------------------------------------------------------
// Hysteretic CO2/brine relative permeability with Land trapping
// Streaming Q16 evaluation of relative permeability, slope and trapped
// saturation for one grid cell per beat.
// ----------------------------------------------------------------------------
// The unit accepts one beat per clock while in_stall_o is low and returns
// one result beat for each input beat, in order. Three 24-stage pipelined
// dividers lie in series: effective saturation, the Land residual and
// finally the permeability, slope and trapped saturation quotients, with
// register stages for the multiplications between them.
// All stages advance together; when a result waits at the output under
// stall, the whole pipeline holds and in_stall_o is raised. Configuration
// registers are written through the cfg channel, which is always ready, and
// must only change while no beat is in flight.
`include "hysteretic_relperm_land_trapping_unit_macros.svh"

module hysteretic_relperm_land_trapping_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [17:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [17:0] sat_now_i,
  input  logic signed [17:0] sat_max_history_i,
  input  logic               phase_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [17:0]        rel_perm_o,
  output logic signed [24:0] rel_perm_slope_o,
  output logic [16:0]        trapped_sat_o,
  output logic               config_error_o
);
  import hrlt_pkg::*;

  // Input register.
  typedef struct packed {
    logic               v;
    logic signed [17:0] sn;
    logic signed [17:0] sm;
    logic               ph;
  } sa_t;

  // Effective saturations known.
  typedef struct packed {
    logic               v;
    logic signed [17:0] sn;
    logic signed [17:0] sm;
    logic               ph;
    logic [SatW-1:0]    s;
    logic [SatW-1:0]    smax;
  } sb_t;

  // Land denominator products.
  typedef struct packed {
    logic               v;
    logic signed [17:0] sn;
    logic signed [17:0] sm;
    logic               ph;
    logic [SatW-1:0]    s;
    logic [SatW-1:0]    smax;
    logic [DenW-1:0]    p1;
    logic [DenW-1:0]    p2;
    logic [DenW-1:0]    gs;
  } sc_t;

  typedef struct packed {
    logic               v;
    logic signed [17:0] sn;
    logic signed [17:0] sm;
    logic               ph;
    logic [SatW-1:0]    s;
    logic [SatW-1:0]    smax;
    logic [DenW-1:0]    den;
    logic [DenW-1:0]    gs;
  } sd_t;

  // Residual saturation and branch decision known.
  typedef struct packed {
    logic               v;
    logic signed [17:0] sn;
    logic               ph;
    logic [SatW-1:0]    s;
    logic [SatW-1:0]    smax;
    logic [SatW-1:0]    sgr;
    logic [SatW-1:0]    dn;
    logic               drain;
  } se_t;

  typedef struct packed {
    logic               v;
    logic signed [17:0] sn;
    logic               ph;
    logic [SatW-1:0]    dn;
    logic               drain;
    logic [34:0]        m1;
    logic [DenW-1:0]    m2;
    logic [DenW-1:0]    dnd;
    logic [34:0]        lin;
    logic [SatW-1:0]    s_minus;
    logic [SatW-1:0]    diff;
    logic               kr_en;
    logic               sl_en;
    logic               in_clamp;
  } sf_t;

  typedef struct packed {
    logic               v;
    logic signed [17:0] sn;
    logic               ph;
    logic               drain;
    logic               kr_en;
    logic               sl_en;
    logic               in_clamp;
    logic [17:0]        kr_lin;
    logic [SatW-1:0]    dn;
    logic [NumW-1:0]    krnum;
    logic [NumW-1:0]    trnum;
    logic [NumW-1:0]    slnum;
    logic [DenW-1:0]    slden;
  } sg_t;

  // Side data that rides along the final dividers.
  typedef struct packed {
    logic               v;
    logic signed [17:0] sn;
    logic               ph;
    logic               drain;
    logic               kr_en;
    logic               sl_en;
    logic               in_clamp;
    logic [17:0]        kr_lin;
  } lc_t;

  logic [15:0] swr_q, sgrmax_q;
  logic [17:0] krn_q, krw_q;
  logic [SatW-1:0] d_w;

  logic en;

  sa_t a_q, a_d;
  sa_t la_q [QuoW];
  sb_t b_q, b_d;
  sc_t c_q, c_d;
  sd_t d_q, d_d;
  sb_t lb_q [QuoW];
  se_t e_q, e_d;
  sf_t f_q, f_d;
  sg_t g_q, g_d;
  lc_t lc_d;
  lc_t lc_q [QuoW];

  logic [NumW-1:0] num_s, num_m, num_sgr, num_kr, num_tr;
  logic [QuoW-1:0] quo_s, quo_m, quo_sgr, quo_kr, quo_sl, quo_tr;
  logic            ovf_s, ovf_m, ovf_sgr, ovf_kr, ovf_sl, ovf_tr;
  logic            big;
  lc_t             lc_o;
  sb_t             lb_o;

  logic        out_valid_q, out_valid_d;
  logic [17:0] rel_perm_q, rel_perm_d;
  logic [24:0] slope_q, slope_d;
  logic [16:0] trapped_q, trapped_d;
  logic        cerr_q, cerr_d;

  // --------------------------------------------------------------------------
  // Configuration registers. The channel never pushes back.
  // --------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swr_q    <= 16'd0;
      krn_q    <= 18'd65536;
      krw_q    <= 18'd65536;
      sgrmax_q <= 16'd13107;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgResidualWater: swr_q    <= cfg_data_i[15:0];
        CfgMaxNonwetKr:   krn_q    <= cfg_data_i;
        CfgMaxWetKr:      krw_q    <= cfg_data_i;
        CfgMaxTrapped:    sgrmax_q <= cfg_data_i[15:0];
      endcase
    end
  end

  // Mobile pore fraction 1 - Swr, never zero.
  assign d_w = OneQ - {1'b0, swr_q};

  // The pipeline moves as a whole unless a finished result is held back.
  assign en          = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !en;

  // --------------------------------------------------------------------------
  // Dividers.
  // --------------------------------------------------------------------------
  hrlt_div u_div_s (
    .clk_i(clk_i), .en_i(en), .num_i(num_s), .den_i(DenW'(d_w)),
    .quo_o(quo_s), .ovf_o(ovf_s)
  );

  hrlt_div u_div_m (
    .clk_i(clk_i), .en_i(en), .num_i(num_m), .den_i(DenW'(d_w)),
    .quo_o(quo_m), .ovf_o(ovf_m)
  );

  hrlt_div u_div_sgr (
    .clk_i(clk_i), .en_i(en), .num_i(num_sgr), .den_i(d_q.den),
    .quo_o(quo_sgr), .ovf_o(ovf_sgr)
  );

  hrlt_div u_div_kr (
    .clk_i(clk_i), .en_i(en), .num_i(num_kr), .den_i(DenW'(g_q.dn)),
    .quo_o(quo_kr), .ovf_o(ovf_kr)
  );

  hrlt_div u_div_sl (
    .clk_i(clk_i), .en_i(en), .num_i(g_q.slnum), .den_i(g_q.slden),
    .quo_o(quo_sl), .ovf_o(ovf_sl)
  );

  hrlt_div u_div_tr (
    .clk_i(clk_i), .en_i(en), .num_i(num_tr), .den_i(DenW'(g_q.dn)),
    .quo_o(quo_tr), .ovf_o(ovf_tr)
  );

  // --------------------------------------------------------------------------
  // Stage logic.
  // --------------------------------------------------------------------------
  always_comb begin
    a_d.v  = in_valid_i;
    a_d.sn = sat_now_i;
    a_d.sm = sat_max_history_i;
    a_d.ph = phase_i;

    // Non-positive saturations map to zero effective saturation.
    num_s = (a_q.sn > 0) ? (NumW'(a_q.sn[16:0]) << FracBits) : '0;
    num_m = (a_q.sm > 0) ? (NumW'(a_q.sm[16:0]) << FracBits) : '0;

    // Effective saturation is limited to one.
    b_d.v    = la_q[QuoW-1].v;
    b_d.sn   = la_q[QuoW-1].sn;
    b_d.sm   = la_q[QuoW-1].sm;
    b_d.ph   = la_q[QuoW-1].ph;
    b_d.s    = (ovf_s || quo_s > QuoW'(OneQ)) ? OneQ : quo_s[SatW-1:0];
    b_d.smax = (ovf_m || quo_m > QuoW'(OneQ)) ? OneQ : quo_m[SatW-1:0];

    // Land denominator G*(1 - smax) + D*smax stays positive for smax > 0.
    c_d.v    = b_q.v;
    c_d.sn   = b_q.sn;
    c_d.sm   = b_q.sm;
    c_d.ph   = b_q.ph;
    c_d.s    = b_q.s;
    c_d.smax = b_q.smax;
    c_d.p1   = DenW'(sgrmax_q) * DenW'(OneQ - b_q.smax);
    c_d.p2   = DenW'(d_w) * DenW'(b_q.smax);
    c_d.gs   = DenW'(sgrmax_q) * DenW'(b_q.smax);

    d_d.v    = c_q.v;
    d_d.sn   = c_q.sn;
    d_d.sm   = c_q.sm;
    d_d.ph   = c_q.ph;
    d_d.s    = c_q.s;
    d_d.smax = c_q.smax;
    d_d.den  = c_q.p1 + c_q.p2;
    d_d.gs   = c_q.gs;

    num_sgr = NumW'(d_q.gs) << FracBits;

    // A residual at or above the turning point leaves no scanning line, so
    // the curve falls back to drainage. This also covers a zero turning point.
    lb_o   = lb_q[QuoW-1];
    big    = ovf_sgr || (quo_sgr >= QuoW'(lb_o.smax));
    e_d.v     = lb_o.v;
    e_d.sn    = lb_o.sn;
    e_d.ph    = lb_o.ph;
    e_d.s     = lb_o.s;
    e_d.smax  = lb_o.smax;
    e_d.sgr   = big ? '0 : quo_sgr[SatW-1:0];
    e_d.dn    = lb_o.smax - e_d.sgr;
    e_d.drain = (lb_o.sn >= lb_o.sm) || big;

    f_d.v        = e_q.v;
    f_d.sn       = e_q.sn;
    f_d.ph       = e_q.ph;
    f_d.dn       = e_q.dn;
    f_d.drain    = e_q.drain;
    f_d.m1       = 35'(krn_q) * 35'(e_q.smax);
    f_d.m2       = DenW'(d_w) * DenW'(e_q.sgr);
    f_d.dnd      = DenW'(e_q.dn) * DenW'(d_w);
    f_d.lin      = 35'(e_q.ph ? krw_q : krn_q) * 35'(e_q.ph ? OneQ - e_q.s : e_q.s);
    f_d.kr_en    = e_q.s > e_q.sgr;
    f_d.sl_en    = (e_q.s > e_q.sgr) && (e_q.s < e_q.smax);
    f_d.s_minus  = f_d.kr_en ? e_q.s - e_q.sgr : '0;
    f_d.diff     = (e_q.smax > e_q.s) ? e_q.smax - e_q.s : '0;
    f_d.in_clamp = (e_q.sn > 0) && (SatW'(e_q.sn[16:0]) < d_w);

    g_d.v        = f_q.v;
    g_d.sn       = f_q.sn;
    g_d.ph       = f_q.ph;
    g_d.drain    = f_q.drain;
    g_d.kr_en    = f_q.kr_en;
    g_d.sl_en    = f_q.sl_en;
    g_d.in_clamp = f_q.in_clamp;
    g_d.kr_lin   = f_q.lin[FracBits +: 18];
    g_d.dn       = f_q.dn;
    g_d.krnum    = NumW'(f_q.m1) * NumW'(f_q.s_minus);
    g_d.trnum    = NumW'(f_q.m2) * NumW'(f_q.diff);
    if (f_q.ph) begin
      g_d.slnum = NumW'(krw_q) << FracBits;
    end else if (f_q.drain) begin
      g_d.slnum = NumW'(krn_q) << FracBits;
    end else begin
      g_d.slnum = NumW'(f_q.m1) << FracBits;
    end
    g_d.slden = (f_q.ph || f_q.drain) ? DenW'(d_w) : f_q.dnd;

    // Dividing by dn * 2^F is the same as dividing the shifted product by dn.
    num_kr = g_q.krnum >> FracBits;
    num_tr = g_q.trnum >> FracBits;

    lc_d.v        = g_q.v;
    lc_d.sn       = g_q.sn;
    lc_d.ph       = g_q.ph;
    lc_d.drain    = g_q.drain;
    lc_d.kr_en    = g_q.kr_en;
    lc_d.sl_en    = g_q.sl_en;
    lc_d.in_clamp = g_q.in_clamp;
    lc_d.kr_lin   = g_q.kr_lin;

    // Result assembly.
    lc_o        = lc_q[QuoW-1];
    out_valid_d = lc_o.v;
    cerr_d      = {1'b0, sgrmax_q} >= d_w;
    if (lc_o.ph || lc_o.drain) begin
      rel_perm_d = lc_o.kr_lin;
    end else begin
      rel_perm_d = lc_o.kr_en ? quo_kr[17:0] : '0;
    end
    if (lc_o.ph) begin
      // Brine slope is negative and saturates at the most negative code.
      if (!lc_o.in_clamp) begin
        slope_d = '0;
      end else begin
        slope_d = ovf_sl ? SlopeMin : 25'd0 - {1'b0, quo_sl};
      end
    end else if (lc_o.drain ? lc_o.in_clamp : lc_o.sl_en) begin
      slope_d = ovf_sl ? SlopeMax : {1'b0, quo_sl};
    end else begin
      slope_d = '0;
    end
    if (lc_o.drain || !(lc_o.sn > 0)) begin
      trapped_d = '0;
    end else if (ovf_tr || quo_tr > QuoW'(lc_o.sn[16:0])) begin
      trapped_d = lc_o.sn[16:0];
    end else begin
      trapped_d = quo_tr[16:0];
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline registers. Only the valid bits are reset.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q.v       <= 1'b0;
      b_q.v       <= 1'b0;
      c_q.v       <= 1'b0;
      d_q.v       <= 1'b0;
      e_q.v       <= 1'b0;
      f_q.v       <= 1'b0;
      g_q.v       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < QuoW; k++) begin
        la_q[k].v <= 1'b0;
        lb_q[k].v <= 1'b0;
        lc_q[k].v <= 1'b0;
      end
    end else if (en) begin
      a_q     <= a_d;
      la_q[0] <= a_q;
      b_q     <= b_d;
      c_q     <= c_d;
      d_q     <= d_d;
      lb_q[0] <= '{v: d_q.v, sn: d_q.sn, sm: d_q.sm, ph: d_q.ph, s: d_q.s, smax: d_q.smax};
      e_q     <= e_d;
      f_q     <= f_d;
      g_q     <= g_d;
      lc_q[0] <= lc_d;
      for (int k = 1; k < QuoW; k++) begin
        la_q[k] <= la_q[k-1];
        lb_q[k] <= lb_q[k-1];
        lc_q[k] <= lc_q[k-1];
      end
      out_valid_q <= out_valid_d;
      rel_perm_q  <= rel_perm_d;
      slope_q     <= slope_d;
      trapped_q   <= trapped_d;
      cerr_q      <= cerr_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign rel_perm_o       = rel_perm_q;
  assign rel_perm_slope_o = $signed(slope_q);
  assign trapped_sat_o    = trapped_q;
  assign config_error_o   = cerr_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `HRLT_ASSERT_IMP(a_eff_sat_range, clk_i, rst_ni, b_q.v,
                   (b_q.s <= OneQ) && (b_q.smax <= OneQ))
  `HRLT_ASSERT_IMP(a_scan_denominator, clk_i, rst_ni, e_q.v && !e_q.drain,
                   (e_q.dn != '0) && (e_q.sgr < e_q.smax))
  `HRLT_ASSERT_NXT(a_hold_on_stall, clk_i, rst_ni, !en, $stable(g_q.v) && $stable(e_q.v))

endmodule
